// ===== rtl/core/three_channel_mean_min_max_tracker_defines.svh =====
// assertion macros for the mean / min / max tracker
`ifndef THREE_CHANNEL_MEAN_MIN_MAX_TRACKER_DEFINES_SVH
`define THREE_CHANNEL_MEAN_MIN_MAX_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCMMM_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("tracker check failed");
`define TCMMM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tracker check failed");
`define TCMMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tracker check failed");
`else
`define TCMMM_ASSERT_ALWAYS(lbl, cond)
`define TCMMM_ASSERT_IMPLY(lbl, ante, cons)
`define TCMMM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/tcmmm_pkg.sv =====
package tcmmm_pkg;

    localparam int TEMP_WINDOW  = 8;
    localparam int HUMID_WINDOW = 8;
    localparam int PRESS_WINDOW = 8;
    localparam int WIN_MAX_TH   = (TEMP_WINDOW > HUMID_WINDOW) ? TEMP_WINDOW : HUMID_WINDOW;
    localparam int WIN_MAX      = (WIN_MAX_TH > PRESS_WINDOW) ? WIN_MAX_TH : PRESS_WINDOW;

    localparam int TEMP_W  = 15;
    localparam int HUMID_W = 14;
    localparam int PRESS_W = 17;

    // common signed form of a channel value, and its stored form
    localparam int VAL_W = PRESS_W + 1;
    localparam int MEM_W = PRESS_W;

    localparam int CNT_W     = $clog2(WIN_MAX + 1);
    localparam int IDX_W     = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
    localparam int CH_W      = 2;
    localparam int ADDR_W    = CH_W + IDX_W;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // mean by reciprocal: exact while the error stays below 1/count
    localparam int SUM_W  = VAL_W + CNT_W;
    localparam int MAG_W  = SUM_W;
    localparam int RCP_K  = MAG_W + CNT_W;
    localparam int RCP_W  = RCP_K + 1;
    localparam int PROD_W = MAG_W + RCP_W;

    localparam int APB_DW      = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_LSB = 2;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_BLOCK = 2'd0;
    localparam t_mode MODE_SLIDE = 2'd1;
    localparam t_mode MODE_RESET = MODE_SLIDE;

    localparam logic REG_MODE = 1'b0;

    typedef logic [CH_W-1:0] t_chan;
    localparam t_chan CH_TEMP  = 2'd0;
    localparam t_chan CH_HUMID = 2'd1;
    localparam t_chan CH_PRESS = 2'd2;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [WIN_MAX:0][RCP_W-1:0] t_rcp_tab;

    function automatic t_cnt win_size(input t_chan ch);
        t_cnt sz;
        case (ch)
            CH_TEMP:  sz = CNT_W'(TEMP_WINDOW);
            CH_HUMID: sz = CNT_W'(HUMID_WINDOW);
            default:  sz = CNT_W'(PRESS_WINDOW);
        endcase
        return sz;
    endfunction

    // ceil(2^RCP_K / n) for every count n from 1 to WIN_MAX, by long division at elaboration
    function automatic t_rcp_tab rcp_table();
        t_rcp_tab tab;
        logic [CNT_W:0] rem;
        logic [RCP_W-1:0] quo;
        tab = '0;
        for (int n = 1; n <= WIN_MAX; n++) begin
            rem = '0;
            quo = '0;
            for (int b = RCP_K; b >= 0; b--) begin
                rem = {rem[CNT_W-1:0], (b == RCP_K)};
                if (rem >= (CNT_W + 1)'(n)) begin
                    rem    = rem - (CNT_W + 1)'(n);
                    quo[b] = 1'b1;
                end
            end
            tab[n] = (rem != '0) ? quo + RCP_W'(1) : quo;
        end
        return tab;
    endfunction

    localparam t_rcp_tab RCP_TAB = rcp_table();

endpackage

// ===== rtl/core/tcmmm_ram.sv =====
module tcmmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/three_channel_mean_min_max_tracker.sv =====
// Three-channel mean / min / max tracker.
// Input channel: i_in_valid / o_in_stall with one temperature, humidity and
// pressure reading and a validity flag. An item with i_reading_ok low changes
// nothing and returns the held values with an empty update mask.
// Output channel: o_out_valid / i_out_stall, one result item per input item:
// the published value of each channel, its lowest and highest published value,
// the update mask and the have-values flags.
// Mode register at byte address 0 of the APB port: 0 block mean,
// 1 sliding mean (reset value), 2 and 3 raw pass-through.
// Items are handled one at a time; o_in_stall is high from acceptance until
// the result is loaded into the output register. The channels are processed
// in turn: a raw value passes S_CHAN and S_UPD; a mean over n entries passes
// S_CHAN, S_READ, S_MUL, S_DIV and S_UPD, where S_READ reads each window entry
// through the single read port of the window RAM. An invalid item goes from
// S_IDLE straight to S_PUB; windows hold 8 entries; the next item is taken in
// the cycle after the result is loaded.
// The result register frees the block while the receiver stalls; only a
// second result waits on it. Reset clears counts, extremes and flags and
// sets the sliding mode; window contents are never read before written.
`include "three_channel_mean_min_max_tracker_defines.svh"

module three_channel_mean_min_max_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcmmm_pkg::PADDR_W-1:0]     paddr,
    input  logic [tcmmm_pkg::APB_DW-1:0]      pwdata,
    output logic [tcmmm_pkg::APB_DW-1:0]      prdata,
    output logic                              pready,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [tcmmm_pkg::TEMP_W-1:0]  i_temp_reading,
    input  logic [tcmmm_pkg::HUMID_W-1:0]     i_humid_reading,
    input  logic [tcmmm_pkg::PRESS_W-1:0]     i_press_reading,
    input  logic                              i_reading_ok,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [tcmmm_pkg::TEMP_W-1:0]  o_temp_value,
    output logic [tcmmm_pkg::HUMID_W-1:0]     o_humid_value,
    output logic [tcmmm_pkg::PRESS_W-1:0]     o_press_value,
    output logic signed [tcmmm_pkg::TEMP_W-1:0]  o_temp_lowest,
    output logic signed [tcmmm_pkg::TEMP_W-1:0]  o_temp_highest,
    output logic [tcmmm_pkg::HUMID_W-1:0]     o_humid_lowest,
    output logic [tcmmm_pkg::HUMID_W-1:0]     o_humid_highest,
    output logic [tcmmm_pkg::PRESS_W-1:0]     o_press_lowest,
    output logic [tcmmm_pkg::PRESS_W-1:0]     o_press_highest,
    output logic [2:0]                        o_updated_mask,
    output logic [2:0]                        o_have_values
);

    import tcmmm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAN,
        S_READ,
        S_MUL,
        S_DIV,
        S_UPD,
        S_PUB
    } t_state;

    t_state                    r_state;
    t_mode                     r_mode;
    t_val                      r_raw [3];
    t_val                      r_pub [3];
    t_val                      r_lo [3];
    t_val                      r_hi [3];
    t_cnt                      r_fill [3];
    logic [IDX_W-1:0]          r_head [3];
    logic [2:0]                r_seen;
    logic [2:0]                r_mask;
    t_chan                     r_ch;
    t_cnt                      r_cnt;
    t_cnt                      r_ridx;
    logic                      r_rd_pend;
    logic signed [SUM_W-1:0]   r_sum;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_neg;
    t_val                      r_val;
    logic                      r_do_pub;

    logic                      r_out_valid;
    logic [TEMP_W-1:0]         r_o_temp_value;
    logic [HUMID_W-1:0]        r_o_humid_value;
    logic [PRESS_W-1:0]        r_o_press_value;
    logic [TEMP_W-1:0]         r_o_temp_lowest;
    logic [TEMP_W-1:0]         r_o_temp_highest;
    logic [HUMID_W-1:0]        r_o_humid_lowest;
    logic [HUMID_W-1:0]        r_o_humid_highest;
    logic [PRESS_W-1:0]        r_o_press_lowest;
    logic [PRESS_W-1:0]        r_o_press_highest;
    logic [2:0]                r_o_mask;
    logic [2:0]                r_o_have;

    // per-channel decision
    t_val                      ch_x;
    t_cnt                      ch_fill;
    logic [IDX_W-1:0]          ch_head;
    t_cnt                      ch_size;
    t_cnt                      blk_next;
    t_cnt                      n_fill;
    logic [IDX_W-1:0]          n_head;
    logic [IDX_W-1:0]          wr_idx;
    logic                      wr_win;
    logic                      need_mean;
    t_cnt                      mean_cnt;
    logic                      pub_raw;

    logic                      ram_we;
    logic                      ram_re;
    logic [MEM_W-1:0]          ram_rdata;
    t_val                      rd_val;

    logic [MAG_W-1:0]          sum_mag;
    logic [MAG_W-1:0]          mul_b;
    logic [MAG_W-1:0]          quo;
    t_val                      quo_val;

    logic                      cfg_wr;
    logic                      rd_issue;
    logic                      out_free;

    always_comb begin
        ch_x      = r_raw[r_ch];
        ch_fill   = r_fill[r_ch];
        ch_head   = r_head[r_ch];
        ch_size   = win_size(r_ch);
        blk_next  = '0;
        n_fill    = ch_fill;
        n_head    = ch_head;
        wr_idx    = ch_fill[IDX_W-1:0];
        wr_win    = 1'b0;
        need_mean = 1'b0;
        mean_cnt  = ch_size;
        pub_raw   = 1'b1;
        case (r_mode)
            MODE_BLOCK: begin
                wr_win   = 1'b1;
                // a full window restarts at the first entry
                wr_idx   = (ch_fill >= ch_size) ? '0 : ch_fill[IDX_W-1:0];
                blk_next = CNT_W'(wr_idx) + CNT_W'(1);
                if (blk_next >= ch_size) begin
                    n_fill    = '0;
                    need_mean = 1'b1;
                end else begin
                    n_fill  = blk_next;
                    pub_raw = !r_seen[r_ch];
                end
            end
            MODE_SLIDE: begin
                wr_win    = 1'b1;
                need_mean = 1'b1;
                if (ch_fill < ch_size) begin
                    wr_idx   = ch_fill[IDX_W-1:0];
                    n_fill   = ch_fill + CNT_W'(1);
                    n_head   = '0;
                    mean_cnt = ch_fill + CNT_W'(1);
                end else begin
                    // full window: overwrite the oldest entry
                    wr_idx = ch_head;
                    n_head = (CNT_W'(ch_head) + CNT_W'(1) == ch_size) ? '0
                                                                    : ch_head + IDX_W'(1);
                end
            end
            default: begin
                wr_win = 1'b0;
            end
        endcase
    end

    assign ram_we   = (r_state == S_CHAN) && wr_win;
    assign rd_issue = r_ridx != r_cnt;
    assign ram_re   = (r_state == S_READ) && rd_issue;

    tcmmm_ram #(
        .WIDTH (MEM_W),
        .DEPTH (RAM_DEPTH)
    ) u_win_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr ({r_ch, wr_idx}),
        .i_wr_data (ch_x[MEM_W-1:0]),
        .i_rd_en   (ram_re),
        .i_rd_addr ({r_ch, r_ridx[IDX_W-1:0]}),
        .o_rd_data (ram_rdata)
    );

    // temperature entries are stored sign-extended
    assign rd_val  = (r_ch == CH_TEMP) ? t_val'({ram_rdata[MEM_W-1], ram_rdata})
                                       : t_val'({1'b0, ram_rdata});

    assign sum_mag = r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);
    assign mul_b   = sum_mag + MAG_W'(r_cnt >> 1);
    assign quo     = r_prod[RCP_K +: MAG_W];
    assign quo_val = t_val'(quo[VAL_W-1:0]);

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (cfg_wr && (paddr[REG_IDX_LSB] == REG_MODE)) begin
            r_mode <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[REG_IDX_LSB] == REG_MODE) begin
            prdata = APB_DW'(r_mode);
        end
    end

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_seen      <= '0;
            r_mask      <= '0;
            r_ch        <= CH_TEMP;
            r_rd_pend   <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_fill[k] <= '0;
                r_head[k] <= '0;
                r_pub[k]  <= '0;
                r_lo[k]   <= '0;
                r_hi[k]   <= '0;
            end
        end else begin
            // a result taken while a new one is loaded is handled in S_PUB
            if (r_out_valid && !i_out_stall && (r_state != S_PUB)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_raw[CH_TEMP]  <= t_val'(i_temp_reading);
                        r_raw[CH_HUMID] <= t_val'(i_humid_reading);
                        r_raw[CH_PRESS] <= t_val'(i_press_reading);
                        r_mask          <= '0;
                        r_ch            <= CH_TEMP;
                        r_state         <= i_reading_ok ? S_CHAN : S_PUB;
                    end
                end
                S_CHAN: begin
                    r_fill[r_ch] <= n_fill;
                    r_head[r_ch] <= n_head;
                    if (need_mean) begin
                        r_cnt     <= mean_cnt;
                        r_ridx    <= '0;
                        r_sum     <= '0;
                        r_rd_pend <= 1'b0;
                        r_state   <= S_READ;
                    end else begin
                        r_val    <= ch_x;
                        r_do_pub <= pub_raw;
                        r_state  <= S_UPD;
                    end
                end
                S_READ: begin
                    if (rd_issue) begin
                        r_ridx <= r_ridx + CNT_W'(1);
                    end
                    r_rd_pend <= rd_issue;
                    if (r_rd_pend) begin
                        r_sum <= r_sum + SUM_W'(rd_val);
                    end
                    if (!rd_issue) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // rounded mean: (|sum| + n/2) / n, sign restored after
                    r_prod  <= mul_b * RCP_TAB[r_cnt];
                    r_neg   <= r_sum[SUM_W-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_val    <= r_neg ? -quo_val : quo_val;
                    r_do_pub <= 1'b1;
                    r_state  <= S_UPD;
                end
                S_UPD: begin
                    if (r_do_pub) begin
                        r_pub[r_ch] <= r_val;
                        if (!r_seen[r_ch]) begin
                            r_lo[r_ch] <= r_val;
                            r_hi[r_ch] <= r_val;
                        end else begin
                            if (r_val < r_lo[r_ch]) begin
                                r_lo[r_ch] <= r_val;
                            end
                            if (r_val > r_hi[r_ch]) begin
                                r_hi[r_ch] <= r_val;
                            end
                        end
                        r_seen[r_ch] <= 1'b1;
                        r_mask[r_ch] <= 1'b1;
                    end
                    if (r_ch == CH_PRESS) begin
                        r_state <= S_PUB;
                    end else begin
                        r_ch    <= r_ch + CH_W'(1);
                        r_state <= S_CHAN;
                    end
                end
                S_PUB: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_o_temp_value    <= r_pub[CH_TEMP][TEMP_W-1:0];
                        r_o_humid_value   <= r_pub[CH_HUMID][HUMID_W-1:0];
                        r_o_press_value   <= r_pub[CH_PRESS][PRESS_W-1:0];
                        r_o_temp_lowest   <= r_lo[CH_TEMP][TEMP_W-1:0];
                        r_o_temp_highest  <= r_hi[CH_TEMP][TEMP_W-1:0];
                        r_o_humid_lowest  <= r_lo[CH_HUMID][HUMID_W-1:0];
                        r_o_humid_highest <= r_hi[CH_HUMID][HUMID_W-1:0];
                        r_o_press_lowest  <= r_lo[CH_PRESS][PRESS_W-1:0];
                        r_o_press_highest <= r_hi[CH_PRESS][PRESS_W-1:0];
                        r_o_mask          <= r_mask;
                        r_o_have          <= r_seen;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = r_state != S_IDLE;
    assign o_out_valid     = r_out_valid;
    assign o_temp_value    = r_o_temp_value;
    assign o_humid_value   = r_o_humid_value;
    assign o_press_value   = r_o_press_value;
    assign o_temp_lowest   = r_o_temp_lowest;
    assign o_temp_highest  = r_o_temp_highest;
    assign o_humid_lowest  = r_o_humid_lowest;
    assign o_humid_highest = r_o_humid_highest;
    assign o_press_lowest  = r_o_press_lowest;
    assign o_press_highest = r_o_press_highest;
    assign o_updated_mask  = r_o_mask;
    assign o_have_values   = r_o_have;

    `TCMMM_ASSERT_ALWAYS(a_fill_in_range, (r_fill[0] <= win_size(CH_TEMP)) && (r_fill[1] <= win_size(CH_HUMID)) && (r_fill[2] <= win_size(CH_PRESS)))
    `TCMMM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `TCMMM_ASSERT_IMPLY(a_mask_has_value, o_out_valid, (o_updated_mask & ~o_have_values) == 3'b000)
    `TCMMM_ASSERT_IMPLY(a_temp_order, o_out_valid && o_have_values[0], o_temp_lowest <= o_temp_highest)

endmodule
